// ----- hw/rtl/delimiter_split_tokenizer_core_defines.svh -----
// Assertion macros shared by the tokenizer RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef DELIMITER_SPLIT_TOKENIZER_CORE_DEFINES_SVH
`define DELIMITER_SPLIT_TOKENIZER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define DST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ----- hw/rtl/dst_pkg.sv -----
// Types and constants of the delimiter split tokenizer.
// Used by the register block, the step logic and the top level.
package dst_pkg;

   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 17;
   localparam int DELIM_CODE_W  = 9;
   localparam int SPLIT_LIMIT_W = 17;
   localparam int CHAR_W        = 8;
   localparam int FIELD_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_CODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_LIMIT = 1'b1;

   localparam logic [DELIM_CODE_W-1:0]  DELIM_CODE_RESET  = 9'd0;
   localparam logic [SPLIT_LIMIT_W-1:0] SPLIT_LIMIT_RESET = 17'h1FFFF;
   localparam logic [DELIM_CODE_W-1:0]  DELIM_SKIP_LEAD   = 9'd32;

   localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      MODE_WS   = 2'd0,
      MODE_ONE  = 2'd1,
      MODE_NONE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ROLE_SKIP    = 2'd0,
      ROLE_CONTENT = 2'd1,
      ROLE_SEP     = 2'd2,
      ROLE_END     = 2'd3
   } role_type;

   typedef struct packed {
      mode_type          mode;
      logic [CHAR_W-1:0] delim_char;
      logic              skip_leading;
      logic              limit_off;
      logic              limit_zero;
      logic [FIELD_W-1:0] limit_max;
   } cfg_type;

   function automatic logic is_white_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
             (c == CHAR_CR) || (c == CHAR_FF) || (c == CHAR_VT);
   endfunction

endpackage

// ----- hw/rtl/dst_cfg_regs.sv -----
// Configuration registers of the tokenizer and their decode into mode flags.
// Depends on dst_pkg.
module dst_cfg_regs import dst_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [DELIM_CODE_W-1:0]  delim_code_ff;
   logic [DELIM_CODE_W-1:0]  delim_code_in;
   logic [SPLIT_LIMIT_W-1:0] split_limit_ff;
   logic [SPLIT_LIMIT_W-1:0] split_limit_in;

   always_comb begin
      delim_code_in  = delim_code_ff;
      split_limit_in = split_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIM_CODE:  delim_code_in  = csr_wdata[DELIM_CODE_W-1:0];
            CSR_SPLIT_LIMIT: split_limit_in = csr_wdata[SPLIT_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_code_ff  <= DELIM_CODE_RESET;
         split_limit_ff <= SPLIT_LIMIT_RESET;
      end else begin
         delim_code_ff  <= delim_code_in;
         split_limit_ff <= split_limit_in;
      end
   end

   always_comb begin
      if (delim_code_ff[DELIM_CODE_W-1]) begin
         cfg.mode = MODE_NONE;
      end else if ((delim_code_ff[CHAR_W-1:0] == CHAR_END) ||
                   (delim_code_ff[CHAR_W-1:0] == CHAR_SPACE)) begin
         cfg.mode = MODE_WS;
      end else begin
         cfg.mode = MODE_ONE;
      end
      cfg.delim_char   = delim_code_ff[CHAR_W-1:0];
      cfg.skip_leading = (delim_code_ff == DELIM_SKIP_LEAD);
      cfg.limit_zero   = (split_limit_ff == '0);
      cfg.limit_off    = split_limit_ff[SPLIT_LIMIT_W-1] || (split_limit_ff == '0);
      cfg.limit_max    = split_limit_ff[FIELD_W-1:0];
   end

endmodule

// ----- hw/rtl/dst_step.sv -----
// Classification of one byte and the next value of the per-string state.
// Depends on dst_pkg.
module dst_step import dst_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  cfg_type                 cfg,
   input  logic [CHAR_W-1:0]       char_in,
   input  logic [COUNT_WIDTH-1:0]  token_count,
   input  logic [COUNT_WIDTH-1:0]  trailing,
   input  logic                    in_run,
   input  logic                    started,
   input  logic                    overflowed,
   output role_type                role,
   output logic [FIELD_W-1:0]      token_index,
   output logic [FIELD_W-1:0]      item_count,
   output logic                    count_overflow,
   output logic [COUNT_WIDTH-1:0]  token_count_next,
   output logic [COUNT_WIDTH-1:0]  trailing_next,
   output logic                    in_run_next,
   output logic                    started_next,
   output logic                    overflowed_next
);

   localparam int CMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                   is_delim;
   logic                   skip;
   logic                   cap_ok;
   logic                   run_cont;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] cur_trail;
   logic                   cur_run;
   logic [COUNT_WIDTH-1:0] final_cnt;

   always_comb begin
      case (cfg.mode)
         MODE_WS:  is_delim = is_white_space(char_in);
         MODE_ONE: is_delim = (char_in == cfg.delim_char);
         default:  is_delim = 1'b0;
      endcase

      skip      = !started && cfg.skip_leading && is_delim;
      cur_count = started ? token_count : COUNT_WIDTH'(1);
      cur_trail = started ? trailing : '0;
      cur_run   = started && in_run;
      cap_ok    = cfg.limit_off || (CMP_W'(cur_count) < CMP_W'(cfg.limit_max));
      run_cont  = (cfg.mode == MODE_WS) && cur_run && is_delim;

      if (!started) begin
         final_cnt = '0;
      end else if (cfg.limit_zero) begin
         final_cnt = token_count - trailing;
      end else begin
         final_cnt = token_count;
      end

      token_count_next = token_count;
      trailing_next    = trailing;
      in_run_next      = in_run;
      started_next     = started;
      overflowed_next  = overflowed;
      role             = ROLE_CONTENT;
      token_index      = '0;
      item_count       = '0;
      count_overflow   = overflowed;

      if (char_in == CHAR_END) begin
         role             = ROLE_END;
         item_count       = FIELD_W'(final_cnt);
         token_count_next = '0;
         trailing_next    = '0;
         in_run_next      = 1'b0;
         started_next     = 1'b0;
         overflowed_next  = 1'b0;
      end else if (skip) begin
         role = ROLE_SKIP;
      end else begin
         started_next     = 1'b1;
         token_count_next = cur_count;
         trailing_next    = cur_trail;
         in_run_next      = cur_run;
         if (run_cont) begin
            role = ROLE_SEP;
         end else if (is_delim && cap_ok) begin
            if (cur_count != COUNT_MAX) begin
               token_count_next = cur_count + COUNT_WIDTH'(1);
               trailing_next    = cur_trail + COUNT_WIDTH'(1);
            end else begin
               overflowed_next = 1'b1;
            end
            in_run_next = 1'b1;
            role        = ROLE_SEP;
         end else begin
            in_run_next   = 1'b0;
            trailing_next = '0;
            role          = ROLE_CONTENT;
         end
         token_index    = FIELD_W'(token_count_next - COUNT_WIDTH'(1));
         count_overflow = overflowed_next;
      end
   end

endmodule

// ----- hw/rtl/delimiter_split_tokenizer_core.sv -----
// Delimiter split tokenizer: one string byte in, one classified beat out.
// An accepted req beat is held in the input register, classified by dst_step and held
// in the output register for rsp. Throughput: one beat per cycle unless rsp stalls;
// each register takes a new beat whenever it is empty or its beat moves on. Reset
// clears both stages and the string state; delim_code becomes 0 and split_limit -1.
// Depends on dst_pkg, dst_cfg_regs, dst_step.
`include "delimiter_split_tokenizer_core_defines.svh"

module delimiter_split_tokenizer_core import dst_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAR_W-1:0]      req_char_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_role,
   output logic [FIELD_W-1:0]     rsp_token_index,
   output logic [FIELD_W-1:0]     rsp_item_count,
   output logic                   rsp_count_overflow,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   cfg_type cfg;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   logic               out_valid_ff;
   logic               out_valid_in;
   role_type           role_ff;
   role_type           role_in;
   logic [FIELD_W-1:0] index_ff;
   logic [FIELD_W-1:0] index_in;
   logic [FIELD_W-1:0] count_ff;
   logic [FIELD_W-1:0] count_in;
   logic               ovf_ff;
   logic               ovf_in;

   logic [COUNT_WIDTH-1:0] token_count_ff;
   logic [COUNT_WIDTH-1:0] token_count_in;
   logic [COUNT_WIDTH-1:0] trailing_ff;
   logic [COUNT_WIDTH-1:0] trailing_in;
   logic                   in_run_ff;
   logic                   in_run_in;
   logic                   started_ff;
   logic                   started_in;
   logic                   overflowed_ff;
   logic                   overflowed_in;

   logic out_free;
   logic advance;

   dst_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dst_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg              (cfg),
      .char_in          (char_ff),
      .token_count      (token_count_ff),
      .trailing         (trailing_ff),
      .in_run           (in_run_ff),
      .started          (started_ff),
      .overflowed       (overflowed_ff),
      .role             (role_in),
      .token_index      (index_in),
      .item_count       (count_in),
      .count_overflow   (ovf_in),
      .token_count_next (token_count_in),
      .trailing_next    (trailing_in),
      .in_run_next      (in_run_in),
      .started_next     (started_in),
      .overflowed_next  (overflowed_in)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign char_in      = (req_valid && req_ready) ? req_char_in : char_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         token_count_ff <= '0;
         trailing_ff    <= '0;
         in_run_ff      <= 1'b0;
         started_ff     <= 1'b0;
         overflowed_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            token_count_ff <= token_count_in;
            trailing_ff    <= trailing_in;
            in_run_ff      <= in_run_in;
            started_ff     <= started_in;
            overflowed_ff  <= overflowed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (advance) begin
         role_ff  <= role_in;
         index_ff <= index_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_role           = role_ff;
   assign rsp_token_index    = index_ff;
   assign rsp_item_count     = count_ff;
   assign rsp_count_overflow = ovf_ff;

   `DST_ASSERT_NEXT(a_end_clears_string, clock, reset,
      advance && (role_in == ROLE_END), !started_ff && (token_count_ff == '0))
   `DST_ASSERT_IMP(a_started_has_token, clock, reset,
      started_ff, token_count_ff != '0)
   `DST_ASSERT_IMP(a_trailing_below_count, clock, reset,
      started_ff, trailing_ff < token_count_ff)
   `DST_ASSERT_IMP(a_overflow_at_max, clock, reset,
      overflowed_ff, token_count_ff == COUNT_MAX)
   `DST_ASSERT_IMP(a_count_only_at_end, clock, reset,
      rsp_valid && (rsp_role != ROLE_END), rsp_item_count == '0)

endmodule
